@@ rtl/i16alu_pkg.sv @@
package i16alu_pkg;

    localparam int unsigned DATA_W = 16;
    localparam int unsigned CMD_W  = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD = 4'd0,
        CMD_SUB = 4'd1,
        CMD_MUL = 4'd2,
        CMD_DIV = 4'd3,
        CMD_MOD = 4'd4,
        CMD_EQ  = 4'd5,
        CMD_NE  = 4'd6,
        CMD_LT  = 4'd7,
        CMD_GT  = 4'd8,
        CMD_LE  = 4'd9,
        CMD_GE  = 4'd10,
        CMD_AND = 4'd11,
        CMD_OR  = 4'd12,
        CMD_XOR = 4'd13,
        CMD_NEG = 4'd14,
        CMD_NOT = 4'd15
    } t_cmd;

    localparam logic [DATA_W-1:0] TRUE_VAL  = 16'hFFFF;
    localparam logic [DATA_W-1:0] FALSE_VAL = 16'h0000;

    // Side information that travels alongside the divider data.
    typedef struct packed {
        logic              valid;
        logic              is_div;
        logic              is_mod;
        logic              div_zero;
        logic              q_neg;
        logic              r_neg;
        logic [DATA_W-1:0] value;
    } t_tag;

endpackage

@@ rtl/int16_basic_alu_unit.sv @@
// 16-bit signed integer ALU.
// Input: an item transfers on a rising edge with start high and busy low.
//   busy is always low, so a new item can be taken on every cycle.
//   i_command selects the operation, i_lhs / i_rhs are the operands.
// Output: each item produces one result, o_value plus o_error, shown for
//   exactly one cycle with o_valid high. Results leave in input order.
// Path: the front register loads on the transfer edge; the item then passes
//   the 16 divider cells and the output register, for every operation alike.
//   Throughput: one item per cycle.
// Divide and modulo run through a chain of 16 restoring cells, one quotient
//   bit per cell; other operations are computed up front and ride along the
//   chain with the divider data to keep order.
// Division by zero gives o_value 0 and o_error 1.
// Reset (synchronous, active low) drops every item in flight; no strobe
//   follows until new items enter. The receiver cannot stall the block.
module int16_basic_alu_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [i16alu_pkg::CMD_W-1:0]         i_command,
    input  logic signed [i16alu_pkg::DATA_W-1:0] i_lhs,
    input  logic signed [i16alu_pkg::DATA_W-1:0] i_rhs,
    output logic                                 o_valid,
    output logic signed [i16alu_pkg::DATA_W-1:0] o_value,
    output logic                                 o_error
);

    localparam int unsigned NCELL = i16alu_pkg::DATA_W;

    i16alu_pkg::t_tag              tag [0:NCELL];
    logic [i16alu_pkg::DATA_W-1:0] rem [0:NCELL];
    logic [i16alu_pkg::DATA_W-1:0] quo [0:NCELL];
    logic [i16alu_pkg::DATA_W-1:0] dvs [0:NCELL];

    i16alu_pkg::t_tag              last;
    logic [i16alu_pkg::DATA_W-1:0] n_value;
    logic                          n_error;
    logic                          r_valid;
    logic [i16alu_pkg::DATA_W-1:0] r_value;
    logic                          r_error;

    assign busy = 1'b0;

    i16alu_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (start & ~busy),
        .i_command (i_command),
        .i_lhs     (i_lhs),
        .i_rhs     (i_rhs),
        .o_tag     (tag[0]),
        .o_dvd     (quo[0]),
        .o_dvs     (dvs[0])
    );

    assign rem[0] = '0;

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        i16alu_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tag   (tag[g]),
            .i_rem   (rem[g]),
            .i_quo   (quo[g]),
            .i_dvs   (dvs[g]),
            .o_tag   (tag[g+1]),
            .o_rem   (rem[g+1]),
            .o_quo   (quo[g+1]),
            .o_dvs   (dvs[g+1])
        );
    end

    assign last = tag[NCELL];

    always_comb begin
        n_error = 1'b0;
        if (last.is_div || last.is_mod) begin
            if (last.div_zero) begin
                n_value = '0;
                n_error = 1'b1;
            end else if (last.is_div) begin
                // Most negative over minus one wraps back to itself here.
                n_value = last.q_neg ? (16'h0000 - quo[NCELL]) : quo[NCELL];
            end else begin
                n_value = last.r_neg ? (16'h0000 - rem[NCELL]) : rem[NCELL];
            end
        end else begin
            n_value = last.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= last.valid;
        end
        r_value <= n_value;
        r_error <= n_error;
    end

    assign o_valid = r_valid;
    assign o_value = r_value;
    assign o_error = r_error;

endmodule

@@ rtl/i16alu_front.sv @@
module i16alu_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load,
    input  logic [i16alu_pkg::CMD_W-1:0]      i_command,
    input  logic signed [i16alu_pkg::DATA_W-1:0] i_lhs,
    input  logic signed [i16alu_pkg::DATA_W-1:0] i_rhs,
    output i16alu_pkg::t_tag                  o_tag,
    output logic [i16alu_pkg::DATA_W-1:0]     o_dvd,
    output logic [i16alu_pkg::DATA_W-1:0]     o_dvs
);

    i16alu_pkg::t_cmd                    cmd;
    i16alu_pkg::t_tag                    n_tag;
    i16alu_pkg::t_tag                    r_tag;
    logic [2*i16alu_pkg::DATA_W-1:0]     prod;
    logic [i16alu_pkg::DATA_W-1:0]       n_dvd;
    logic [i16alu_pkg::DATA_W-1:0]       n_dvs;
    logic [i16alu_pkg::DATA_W-1:0]       r_dvd;
    logic [i16alu_pkg::DATA_W-1:0]       r_dvs;

    assign cmd  = i16alu_pkg::t_cmd'(i_command);
    // Low half of the product is the same for signed and unsigned operands.
    assign prod = {16'h0000, i_lhs} * {16'h0000, i_rhs};

    always_comb begin
        n_dvd = i_lhs[15] ? (16'h0000 - i_lhs) : i_lhs;
        n_dvs = i_rhs[15] ? (16'h0000 - i_rhs) : i_rhs;

        n_tag          = '0;
        n_tag.valid    = i_load;
        n_tag.div_zero = (i_rhs == 16'h0000);
        n_tag.q_neg    = i_lhs[15] ^ i_rhs[15];
        n_tag.r_neg    = i_lhs[15];

        unique case (cmd)
            i16alu_pkg::CMD_ADD: n_tag.value = i_lhs + i_rhs;
            i16alu_pkg::CMD_SUB: n_tag.value = i_lhs - i_rhs;
            i16alu_pkg::CMD_MUL: n_tag.value = prod[15:0];
            i16alu_pkg::CMD_DIV: n_tag.is_div = 1'b1;
            i16alu_pkg::CMD_MOD: n_tag.is_mod = 1'b1;
            i16alu_pkg::CMD_EQ:  n_tag.value = (i_lhs == i_rhs) ? i16alu_pkg::TRUE_VAL
                                                                 : i16alu_pkg::FALSE_VAL;
            i16alu_pkg::CMD_NE:  n_tag.value = (i_lhs != i_rhs) ? i16alu_pkg::TRUE_VAL
                                                                 : i16alu_pkg::FALSE_VAL;
            i16alu_pkg::CMD_LT:  n_tag.value = (i_lhs <  i_rhs) ? i16alu_pkg::TRUE_VAL
                                                                 : i16alu_pkg::FALSE_VAL;
            i16alu_pkg::CMD_GT:  n_tag.value = (i_lhs >  i_rhs) ? i16alu_pkg::TRUE_VAL
                                                                 : i16alu_pkg::FALSE_VAL;
            i16alu_pkg::CMD_LE:  n_tag.value = (i_lhs <= i_rhs) ? i16alu_pkg::TRUE_VAL
                                                                 : i16alu_pkg::FALSE_VAL;
            i16alu_pkg::CMD_GE:  n_tag.value = (i_lhs >= i_rhs) ? i16alu_pkg::TRUE_VAL
                                                                 : i16alu_pkg::FALSE_VAL;
            i16alu_pkg::CMD_AND: n_tag.value = i_lhs & i_rhs;
            i16alu_pkg::CMD_OR:  n_tag.value = i_lhs | i_rhs;
            i16alu_pkg::CMD_XOR: n_tag.value = i_lhs ^ i_rhs;
            i16alu_pkg::CMD_NEG: n_tag.value = 16'h0000 - i_lhs;
            i16alu_pkg::CMD_NOT: n_tag.value = ~i_lhs;
            default:             n_tag.value = i16alu_pkg::FALSE_VAL;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else begin
            r_tag <= n_tag;
        end
        r_dvd <= n_dvd;
        r_dvs <= n_dvs;
    end

    assign o_tag = r_tag;
    assign o_dvd = r_dvd;
    assign o_dvs = r_dvs;

endmodule

@@ rtl/i16alu_cell.sv @@
module i16alu_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  i16alu_pkg::t_tag              i_tag,
    input  logic [i16alu_pkg::DATA_W-1:0] i_rem,
    input  logic [i16alu_pkg::DATA_W-1:0] i_quo,
    input  logic [i16alu_pkg::DATA_W-1:0] i_dvs,
    output i16alu_pkg::t_tag              o_tag,
    output logic [i16alu_pkg::DATA_W-1:0] o_rem,
    output logic [i16alu_pkg::DATA_W-1:0] o_quo,
    output logic [i16alu_pkg::DATA_W-1:0] o_dvs
);

    logic [i16alu_pkg::DATA_W:0]   trial;
    logic [i16alu_pkg::DATA_W:0]   diff;
    logic [i16alu_pkg::DATA_W-1:0] n_rem;
    logic [i16alu_pkg::DATA_W-1:0] n_quo;
    i16alu_pkg::t_tag              r_tag;
    logic [i16alu_pkg::DATA_W-1:0] r_rem;
    logic [i16alu_pkg::DATA_W-1:0] r_quo;
    logic [i16alu_pkg::DATA_W-1:0] r_dvs;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    // The quotient register doubles as the dividend shift line.
    assign trial = {i_rem, i_quo[i16alu_pkg::DATA_W-1]};
    assign diff  = trial - {1'b0, i_dvs};

    always_comb begin
        if (!diff[i16alu_pkg::DATA_W]) begin
            n_rem = diff[i16alu_pkg::DATA_W-1:0];
            n_quo = {i_quo[i16alu_pkg::DATA_W-2:0], 1'b1};
        end else begin
            n_rem = trial[i16alu_pkg::DATA_W-1:0];
            n_quo = {i_quo[i16alu_pkg::DATA_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else begin
            r_tag <= i_tag;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= i_dvs;
    end

    assign o_tag = r_tag;
    assign o_rem = r_rem;
    assign o_quo = r_quo;
    assign o_dvs = r_dvs;

endmodule
